FILE: rtl/core/scoped_binding_table_defines.svh
// ----------------------------------------------------------------------------
// scoped_binding_table_defines.svh
// Assertion macros for the scoped binding table.
// ----------------------------------------------------------------------------
`ifndef SCOPED_BINDING_TABLE_DEFINES_SVH
`define SCOPED_BINDING_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define SBT_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scoped_binding_table: invariant violated");
`define SBT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("scoped_binding_table: sequence violated");
`else
`define SBT_ASSERT_ALWAYS(label, cond)
`define SBT_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: rtl/core/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Field widths, item kinds, status codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

  localparam int NAME_W   = 16;
  localparam int HANDLE_W = 32;
  localparam int ENTRY_W  = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  localparam int IN_DATA_W  = NAME_W + HANDLE_W + ENTRY_W;
  localparam int OUT_DATA_W = HANDLE_W + ENTRY_W;

  localparam int DEF_STACK_DEPTH  = 64;
  localparam int DEF_SCOPE_DEPTH  = 16;
  localparam int DEF_GLOBAL_DEPTH = 64;
  localparam int DEF_RESERVED     = 8;

  localparam logic [KIND_W-1:0] K_CALL   = 2'd0;
  localparam logic [KIND_W-1:0] K_RETURN = 2'd1;
  localparam logic [KIND_W-1:0] K_GET    = 2'd2;
  localparam logic [KIND_W-1:0] K_SET    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COLLISION = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_SCOPE  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/scoped_binding_table.sv
// ----------------------------------------------------------------------------
// scoped_binding_table
// Scoped name-to-handle table: a binding stack cut into scope sections plus
// a global table, searched one entry per cycle by a single name comparator.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                  tuser
//  s_*      in   name, handle_in, entry_id              kind
//  m_*      out  handle_out, popped_entry               status
//
//  A call goes straight to its result; a return first reads the innermost scope
//  section. A get scans the bindings from the top of the stack down, then the
//  globals; a set reads the current scope section and scans its entries, or
//  scans the globals at global level. Scans read the binding and global
//  memories into the shared comparator.
//  Reset needs no clearing pass; reserved globals are decoded from the index.
//  A result waits in the output register; a new beat is taken meanwhile, and
//  a second finished result holds the input off until the first is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scoped_binding_table_defines.svh"

module scoped_binding_table #(
  parameter int STACK_DEPTH  = sbt_pkg::DEF_STACK_DEPTH,
  parameter int SCOPE_DEPTH  = sbt_pkg::DEF_SCOPE_DEPTH,
  parameter int GLOBAL_DEPTH = sbt_pkg::DEF_GLOBAL_DEPTH,
  parameter int RESERVED     = sbt_pkg::DEF_RESERVED
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sbt_pkg::IN_DATA_W-1:0]    s_tdata,   // name, handle_in, entry_id
  input  wire logic [sbt_pkg::KIND_W-1:0]       s_tuser,   // kind
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sbt_pkg::OUT_DATA_W-1:0]        m_tdata,   // handle_out, popped_entry
  output logic [sbt_pkg::STATUS_W-1:0]          m_tuser    // status
);
  import sbt_pkg::*;

  localparam int PRE = (RESERVED < GLOBAL_DEPTH) ? RESERVED : GLOBAL_DEPTH;
  localparam int BIW = $clog2(STACK_DEPTH);
  localparam int BCW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(SCOPE_DEPTH);
  localparam int SCW = $clog2(SCOPE_DEPTH + 1);
  localparam int GIW = $clog2(GLOBAL_DEPTH);
  localparam int GCW = $clog2(GLOBAL_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRD   = 3'd1;
  localparam logic [2:0] S_BSCAN = 3'd2;
  localparam logic [2:0] S_GSCAN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  logic [KIND_W-1:0]   kind_q;
  logic [NAME_W-1:0]   name_q;
  logic [HANDLE_W-1:0] hin_q;

  logic [BCW-1:0] bind_count;
  logic [SCW-1:0] scope_count;
  logic [GCW-1:0] global_count;

  logic [BCW-1:0] bptr;
  logic [BCW-1:0] blo;
  logic [GCW-1:0] gptr;
  logic           rd_vld;

  logic [NAME_W-1:0]   bind_names   [STACK_DEPTH];
  logic [HANDLE_W-1:0] bind_handles [STACK_DEPTH];
  logic [BCW-1:0]      scope_starts [SCOPE_DEPTH];
  logic [ENTRY_W-1:0]  scope_entries[SCOPE_DEPTH];
  logic [NAME_W-1:0]   global_names  [GLOBAL_DEPTH];
  logic [HANDLE_W-1:0] global_handles[GLOBAL_DEPTH];

  logic [NAME_W-1:0]   b_rd_name;
  logic [HANDLE_W-1:0] b_rd_handle;
  logic [NAME_W-1:0]   g_rd_name;
  logic [HANDLE_W-1:0] g_rd_handle;
  logic [GIW-1:0]      g_idx_q;
  logic                g_res_q;
  logic [BCW-1:0]      s_rd_start;
  logic [ENTRY_W-1:0]  s_rd_entry;

  logic [STATUS_W-1:0] res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [ENTRY_W-1:0]  res_popped;

  logic                accept;
  logic                sw_en;
  logic                bw_en;
  logic                gw_en;
  logic                b_hit;
  logic                b_done;
  logic                g_hit;
  logic                g_done;
  logic                cmp_eq;
  logic [NAME_W-1:0]   cmp_data;
  logic [HANDLE_W-1:0] g_hit_handle;
  logic [BIW-1:0]      b_rd_addr;
  logic [SIW-1:0]      s_rd_addr;
  logic [BCW-1:0]      bptr_dec;
  logic [SCW-1:0]      scope_dec;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    bptr_dec  = bptr - BCW'(1);
    scope_dec = scope_count - SCW'(1);
    b_rd_addr = bptr_dec[BIW-1:0];
    s_rd_addr = scope_dec[SIW-1:0];

    if (state == S_BSCAN) begin
      cmp_data = b_rd_name;
    end else if (g_res_q) begin
      cmp_data = {{(NAME_W - GIW){1'b0}}, g_idx_q};
    end else begin
      cmp_data = g_rd_name;
    end
    cmp_eq = (cmp_data == name_q);

    g_hit_handle = g_res_q ? {{(HANDLE_W - GIW){1'b0}}, g_idx_q} : g_rd_handle;

    b_hit  = (state == S_BSCAN) && rd_vld && cmp_eq;
    b_done = (state == S_BSCAN) && !rd_vld && (bptr == blo);
    g_hit  = (state == S_GSCAN) && rd_vld && cmp_eq;
    g_done = (state == S_GSCAN) && !rd_vld && (gptr == GCW'(0) || gptr == global_count)
             && (gptr == global_count);

    sw_en = accept && (s_tuser == K_CALL) && (scope_count != SCW'(SCOPE_DEPTH));
    bw_en = b_done && (kind_q == K_SET) && (bind_count != BCW'(STACK_DEPTH));
    gw_en = g_done && (kind_q == K_SET) && (global_count != GCW'(GLOBAL_DEPTH));
  end

  // binding stack memory
  always_ff @(posedge clk) begin
    if (bw_en) begin
      bind_names[bind_count[BIW-1:0]]   <= name_q;
      bind_handles[bind_count[BIW-1:0]] <= hin_q;
    end
    b_rd_name   <= bind_names[b_rd_addr];
    b_rd_handle <= bind_handles[b_rd_addr];
  end

  // scope section memory
  always_ff @(posedge clk) begin
    if (sw_en) begin
      scope_starts[scope_count[SIW-1:0]]  <= bind_count;
      scope_entries[scope_count[SIW-1:0]] <= s_tdata[IN_DATA_W-1 -: ENTRY_W];
    end
    s_rd_start <= scope_starts[s_rd_addr];
    s_rd_entry <= scope_entries[s_rd_addr];
  end

  // global table memory; reserved entries are decoded, not stored
  always_ff @(posedge clk) begin
    if (gw_en) begin
      global_names[global_count[GIW-1:0]]   <= name_q;
      global_handles[global_count[GIW-1:0]] <= hin_q;
    end
    g_rd_name   <= global_names[gptr[GIW-1:0]];
    g_rd_handle <= global_handles[gptr[GIW-1:0]];
    g_idx_q     <= gptr[GIW-1:0];
    g_res_q     <= (gptr < GCW'(PRE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bind_count   <= '0;
      scope_count  <= '0;
      global_count <= GCW'(PRE);
      rd_vld       <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q     <= s_tuser;
            name_q     <= s_tdata[NAME_W-1:0];
            hin_q      <= s_tdata[NAME_W +: HANDLE_W];
            res_handle <= '0;
            res_popped <= '0;
            rd_vld     <= 1'b0;
            unique case (s_tuser)
              K_CALL: begin
                if (scope_count == SCW'(SCOPE_DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status  <= ST_OK;
                  scope_count <= scope_count + SCW'(1);
                end
                state <= S_DONE;
              end
              K_RETURN: begin
                if (scope_count == SCW'(0)) begin
                  res_status <= ST_NO_SCOPE;
                  state      <= S_DONE;
                end else begin
                  state <= S_SRD;
                end
              end
              K_GET: begin
                bptr  <= bind_count;
                blo   <= '0;
                state <= S_BSCAN;
              end
              K_SET: begin
                if (scope_count == SCW'(0)) begin
                  gptr  <= '0;
                  state <= S_GSCAN;
                end else begin
                  state <= S_SRD;
                end
              end
            endcase
          end
        end
        S_SRD: begin
          if (kind_q == K_RETURN) begin
            if (s_rd_start < bind_count) begin
              bind_count <= s_rd_start;
            end
            scope_count <= scope_dec;
            res_status  <= ST_OK;
            res_popped  <= s_rd_entry;
            state       <= S_DONE;
          end else begin
            bptr  <= bind_count;
            blo   <= s_rd_start;
            state <= S_BSCAN;
          end
        end
        S_BSCAN: begin
          if (b_hit) begin
            if (kind_q == K_GET) begin
              res_status <= ST_OK;
              res_handle <= b_rd_handle;
            end else begin
              res_status <= ST_COLLISION;
            end
            state <= S_DONE;
          end else if (b_done) begin
            if (kind_q == K_GET) begin
              gptr  <= '0;
              state <= S_GSCAN;
            end else begin
              if (bw_en) begin
                res_status <= ST_OK;
                bind_count <= bind_count + BCW'(1);
              end else begin
                res_status <= ST_FULL;
              end
              state <= S_DONE;
            end
            rd_vld <= 1'b0;
          end else if (bptr != blo) begin
            bptr   <= bptr_dec;
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        S_GSCAN: begin
          if (g_hit) begin
            if (kind_q == K_GET) begin
              res_status <= ST_OK;
              res_handle <= g_hit_handle;
            end else begin
              res_status <= ST_COLLISION;
            end
            state <= S_DONE;
          end else if (g_done) begin
            if (kind_q == K_GET) begin
              res_status <= ST_NOT_FOUND;
            end else if (gw_en) begin
              res_status   <= ST_OK;
              global_count <= global_count + GCW'(1);
            end else begin
              res_status <= ST_FULL;
            end
            state <= S_DONE;
          end else if (gptr != global_count) begin
            gptr   <= gptr + GCW'(1);
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {res_popped, res_handle};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SBT_ASSERT_ALWAYS(a_bind_bound, bind_count <= BCW'(STACK_DEPTH))
  `SBT_ASSERT_ALWAYS(a_scope_bound, scope_count <= SCW'(SCOPE_DEPTH))
  `SBT_ASSERT_ALWAYS(a_global_bound, (global_count >= GCW'(PRE)) && (global_count <= GCW'(GLOBAL_DEPTH)))
  `SBT_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)

endmodule

`default_nettype wire

FILE: bench/scoped_binding_table_test.sv
// ----------------------------------------------------------------------------
// scoped_binding_table_test
// Streams call, return, get and set beats into the scoped binding table and
// checks every result against an in-bench model of the binding stack, the
// scope sections and the global table. A short directed opener is followed
// by random scope nest/unwind sequences with random stalls on both sides.
// ----------------------------------------------------------------------------
module scoped_binding_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sbt_pkg::*;

  localparam int STK_N   = DEF_STACK_DEPTH;
  localparam int SCOPE_N = DEF_SCOPE_DEPTH;
  localparam int GLOB_N  = DEF_GLOBAL_DEPTH;
  localparam int RSV_N   = DEF_RESERVED;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_OPS   = 1750;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [NAME_W-1:0]   name;
    logic [HANDLE_W-1:0] handle;
    logic [ENTRY_W-1:0]  entry;
  } table_op_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle;
    logic [ENTRY_W-1:0]  popped;
  } table_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;  // name, handle_in, entry_id
  logic [KIND_W-1:0] s_tuser = '0;     // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;      // handle_out, popped_entry
  logic [STATUS_W-1:0] m_tuser;        // status

  scoped_binding_table #(
    .STACK_DEPTH(STK_N),
    .SCOPE_DEPTH(SCOPE_N),
    .GLOBAL_DEPTH(GLOB_N),
    .RESERVED(RSV_N)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #4 clk = ~clk;

  // model state
  logic [NAME_W-1:0]   stk_names[STK_N];
  logic [HANDLE_W-1:0] stk_handles[STK_N];
  int                  stk_count;
  int                  scope_base[SCOPE_N];
  logic [ENTRY_W-1:0]  scope_tag[SCOPE_N];
  int                  scope_depth;
  logic [NAME_W-1:0]   glob_names[GLOB_N];
  logic [HANDLE_W-1:0] glob_handles[GLOB_N];
  int                  glob_count;

  table_op_t  op_queue[$];
  table_res_t expected_results[$];
  int gen_depth = 0;
  int errors = 0;
  int idle_cycles = 0;
  int kind_tally[4] = '{0, 0, 0, 0};
  int status_tally[5] = '{0, 0, 0, 0, 0};
  logic op_taken = 1'b0;
  int send_gap = 0;
  int recv_hold = 0;
  int cycle_n = 0;
  bit quiet = 1'b0;

  function automatic table_res_t resolve_op(table_op_t op);
    table_res_t r;
    bit hit;
    int base;
    r = '{ST_OK, '0, '0};
    hit = 1'b0;
    case (op.kind)
      K_CALL: begin
        if (scope_depth >= SCOPE_N) begin
          r.status = ST_FULL;
        end else begin
          scope_base[scope_depth] = stk_count;
          scope_tag[scope_depth] = op.entry;
          scope_depth++;
        end
      end
      K_RETURN: begin
        if (scope_depth == 0) begin
          r.status = ST_NO_SCOPE;
        end else begin
          scope_depth--;
          if (scope_base[scope_depth] < stk_count) stk_count = scope_base[scope_depth];
          r.popped = scope_tag[scope_depth];
        end
      end
      K_GET: begin
        for (int i = stk_count - 1; i >= 0 && !hit; i--)
          if (stk_names[i] == op.name) begin
            hit = 1'b1;
            r.handle = stk_handles[i];
          end
        for (int i = 0; i < glob_count && !hit; i++)
          if (glob_names[i] == op.name) begin
            hit = 1'b1;
            r.handle = glob_handles[i];
          end
        if (!hit) r.status = ST_NOT_FOUND;
      end
      K_SET: begin
        if (scope_depth == 0) begin
          for (int i = 0; i < glob_count; i++)
            if (glob_names[i] == op.name) hit = 1'b1;
          if (hit) begin
            r.status = ST_COLLISION;
          end else if (glob_count >= GLOB_N) begin
            r.status = ST_FULL;
          end else begin
            glob_names[glob_count] = op.name;
            glob_handles[glob_count] = op.handle;
            glob_count++;
          end
        end else begin
          base = scope_base[scope_depth - 1];
          for (int i = base; i < stk_count; i++)
            if (stk_names[i] == op.name) hit = 1'b1;
          if (hit) begin
            r.status = ST_COLLISION;
          end else if (stk_count >= STK_N) begin
            r.status = ST_FULL;
          end else begin
            stk_names[stk_count] = op.name;
            stk_handles[stk_count] = op.handle;
            stk_count++;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return NAME_W'($urandom_range(0, 23));
    if (r < 85) return NAME_W'($urandom_range(0, 127));
    if (r < 95) return NAME_W'($urandom);
    return (r < 98) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic void push_op(logic [KIND_W-1:0] kind, logic [NAME_W-1:0] name,
                                  logic [HANDLE_W-1:0] handle, logic [ENTRY_W-1:0] entry);
    table_op_t op;
    op = '{kind, name, handle, entry};
    op_queue.push_back(op);
    if (kind == K_CALL && gen_depth < SCOPE_N) gen_depth++;
    if (kind == K_RETURN && gen_depth > 0) gen_depth--;
  endfunction

  // sender
  always @(negedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n % 300 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || op_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        table_op_t op;
        op = op_queue.pop_front();
        s_tdata <= {op.entry, op.handle, op.name};
        s_tuser <= op.kind;
        s_tvalid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      recv_hold <= gap_len();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    table_op_t op;
    table_res_t want;
    logic [HANDLE_W-1:0] got_handle;
    logic [ENTRY_W-1:0] got_popped;
    op_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_handle = m_tdata[HANDLE_W-1:0];
        got_popped = m_tdata[HANDLE_W +: ENTRY_W];
        if (m_tuser <= ST_NO_SCOPE) status_tally[m_tuser]++;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: status %0d handle %h popped %h",
                 m_tuser, got_handle, got_popped);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            errors++;
          end
          if (got_handle !== want.handle) begin
            $error("handle_out: expected %h, got %h", want.handle, got_handle);
            errors++;
          end
          if (got_popped !== want.popped) begin
            $error("popped_entry: expected %h, got %h", want.popped, got_popped);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        op = '{s_tuser, s_tdata[NAME_W-1:0], s_tdata[NAME_W +: HANDLE_W],
               s_tdata[NAME_W+HANDLE_W +: ENTRY_W]};
        kind_tally[op.kind]++;
        expected_results.push_back(resolve_op(op));
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int target;
    int down;
    bit heavy;
    stk_count = 0;
    scope_depth = 0;
    glob_count = RSV_N;
    for (int i = 0; i < STK_N; i++) begin
      stk_names[i] = '0;
      stk_handles[i] = '0;
    end
    for (int i = 0; i < SCOPE_N; i++) begin
      scope_base[i] = 0;
      scope_tag[i] = '0;
    end
    for (int i = 0; i < GLOB_N; i++) begin
      glob_names[i] = (i < RSV_N) ? NAME_W'(i) : '0;
      glob_handles[i] = (i < RSV_N) ? HANDLE_W'(i) : '0;
    end

    // directed opener
    push_op(K_RETURN, 16'h0000, 32'h0, 16'h0000);        // no scope open
    push_op(K_GET, 16'h0000, 32'h0, 16'h0000);           // reserved globals
    push_op(K_GET, 16'h0007, 32'h0, 16'h0000);
    push_op(K_GET, 16'h0008, 32'h0, 16'h0000);           // miss
    push_op(K_GET, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_op(K_SET, 16'h0005, 32'hAAAA_5555, 16'h0000);   // clashes with reserved
    push_op(K_SET, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
    push_op(K_GET, 16'hFFFF, 32'h0, 16'h0000);
    push_op(K_SET, 16'h8000, 32'h0000_0000, 16'hFFFF);
    push_op(K_CALL, 16'h0000, 32'h0, 16'hFFFF);
    push_op(K_CALL, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
    push_op(K_SET, 16'hFFFF, 32'h1234_5678, 16'h0000);   // shadows a global
    push_op(K_SET, 16'hFFFF, 32'h8765_4321, 16'h0000);   // same scope clash
    push_op(K_GET, 16'hFFFF, 32'h0, 16'h0000);
    push_op(K_CALL, 16'h0000, 32'h0, 16'h5A5A);
    push_op(K_SET, 16'h0003, 32'h0000_DEAD, 16'h0000);
    push_op(K_GET, 16'h0003, 32'h0, 16'h0000);
    push_op(K_RETURN, 16'h0000, 32'h0, 16'h0000);
    push_op(K_GET, 16'h0003, 32'h0, 16'h0000);
    push_op(K_RETURN, 16'h0000, 32'h0, 16'h0000);
    push_op(K_RETURN, 16'h0000, 32'h0, 16'h0000);
    push_op(K_RETURN, 16'h0000, 32'h0, 16'h0000);
    push_op(K_GET, 16'h8000, 32'h0, 16'h0000);

    // random nest/unwind sequences; the first one overruns the scope stack
    seg = 0;
    while (op_queue.size() < RAND_OPS + 23) begin
      if (gen_depth == 0) begin
        repeat ((seg == 20) ? 60 : $urandom_range(0, 3))
          push_op(K_SET, pick_name(), $urandom, ENTRY_W'($urandom));
        repeat ($urandom_range(0, 2))
          push_op(K_GET, pick_name(), $urandom, ENTRY_W'($urandom));
      end
      target = (seg == 0 || $urandom_range(0, 7) == 0) ? SCOPE_N + 1
                                                         : $urandom_range(1, SCOPE_N);
      heavy = (seg == 0 || $urandom_range(0, 5) == 0);
      for (int j = gen_depth; j < target; j++) begin
        push_op(K_CALL, NAME_W'($urandom), $urandom, ENTRY_W'($urandom));
        repeat (heavy ? $urandom_range(2, 10) : $urandom_range(0, 3)) begin
          push_op(K_SET, pick_name(), $urandom, ENTRY_W'($urandom));
          if ($urandom_range(0, 2) == 0)
            push_op(K_GET, pick_name(), $urandom, ENTRY_W'($urandom));
        end
      end
      repeat ($urandom_range(1, 6))
        push_op(K_GET, pick_name(), $urandom, ENTRY_W'($urandom));
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 8))
          push_op(KIND_W'($urandom_range(0, 3)), NAME_W'($urandom), $urandom,
                  ENTRY_W'($urandom));
      down = ($urandom_range(0, 3) == 0) ? gen_depth + $urandom_range(1, 2)
                                          : $urandom_range(1, (gen_depth > 0) ? gen_depth : 1);
      repeat (down) begin
        push_op(K_RETURN, NAME_W'($urandom), $urandom, ENTRY_W'($urandom));
        if ($urandom_range(0, 3) == 0)
          push_op(K_GET, pick_name(), $urandom, ENTRY_W'($urandom));
      end
      seg++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (op_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (32) @(posedge clk);
    $display("run: %0d calls, %0d returns, %0d gets, %0d sets accepted",
             kind_tally[K_CALL], kind_tally[K_RETURN], kind_tally[K_GET], kind_tally[K_SET]);
    $display("results: ok %0d, not found %0d, collision %0d, full %0d, no scope %0d",
             status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_COLLISION],
             status_tally[ST_FULL], status_tally[ST_NO_SCOPE]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: scoped_binding_table.f
+incdir+rtl/core
rtl/core/sbt_pkg.sv
rtl/core/scoped_binding_table.sv
bench/scoped_binding_table_test.sv
